// ===== rtl/rce_pkg.sv =====
// ============================================================================
// rce_pkg: shared types and constants of the reference-counted entry cache
// Field widths, request codes, result status codes and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================
package rce_pkg;

  localparam int BLK_W       = 31;
  localparam int OFS_W       = 6;
  localparam int SLOT_W      = 6;
  localparam int OUT_COUNT_W = 16;
  localparam int STATUS_W    = 3;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    RES_HIT      = 3'd0,
    RES_LOADED   = 3'd1,
    RES_FULL     = 3'd2,
    RES_OVERFLOW = 3'd3,
    RES_RELEASED = 3'd4,
    RES_FREED    = 3'd5,
    RES_ROOT     = 3'd6,
    RES_BAD_SLOT = 3'd7
  } res_status_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_IDLE,
    OP_SCAN,
    OP_HIT,
    OP_MISS,
    OP_LOAD,
    OP_CHECK,
    OP_EVAL
  } dp_op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_LOAD,
    S_CHECK,
    S_EVAL
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
    logic   commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic scan_miss;
    logic stack_empty;
    logic slot_ok;
  } dp_status_t;

endpackage

// ===== rtl/rce_datapath.sv =====
// ============================================================================
// rce_datapath: entry table, free stack and result register
// Holds the entry memory and the free-slot stack memory, the request and
// result registers, and carries out the operation that the controller names.
// ============================================================================
module rce_datapath import rce_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [BLK_W-1:0]       key_block,
  input  logic [OFS_W-1:0]       key_offset,
  input  logic [BLK_W-1:0]       parent_block,
  input  logic [OFS_W-1:0]       parent_offset,
  input  logic [SLOT_W-1:0]      slot,
  input  logic                   modified,
  output res_status_t            res_status,
  output logic [SLOT_W-1:0]      res_slot,
  output logic [OUT_COUNT_W-1:0] res_count,
  output logic                   res_wb,
  output logic [BLK_W-1:0]       res_wb_block,
  output logic [OFS_W-1:0]       res_wb_offset
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;

  typedef struct packed {
    logic                  valid;
    logic [BLK_W-1:0]      blk;
    logic [OFS_W-1:0]      ofs;
    logic [BLK_W-1:0]      pblk;
    logic [OFS_W-1:0]      pofs;
    logic [COUNT_BITS-1:0] refs;
  } entry_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  entry_t          entry_mem [ENTRIES];
  logic [AW-1:0]   stack_mem [ENTRIES];

  // Latched request
  logic [BLK_W-1:0]  in_blk;
  logic [OFS_W-1:0]  in_ofs;
  logic [BLK_W-1:0]  in_pblk;
  logic [OFS_W-1:0]  in_pofs;
  logic [SLOT_W-1:0] in_slot;
  logic              in_mod;

  logic [CW-1:0] scan_addr;
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] free_count;
  logic [CW-1:0] free_count_next;
  logic          rd_v;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic [AW-1:0] stk_q;

  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  entry_t        ent_wdata;
  logic          ent_re;
  logic [AW-1:0] ent_raddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [AW-1:0] stk_wdata;
  logic          stk_re;
  logic [AW-1:0] stk_raddr;

  res_status_t            res_status_next;
  logic [SLOT_W-1:0]      res_slot_next;
  logic [COUNT_BITS-1:0]  res_count_next;
  logic                   res_wb_next;
  logic [BLK_W-1:0]       res_wb_block_next;
  logic [OFS_W-1:0]       res_wb_offset_next;

  logic          match;
  logic          scan_end;
  logic          slot_ok;
  logic [AW-1:0] slot_idx;
  logic          empty;
  logic          is_root;

  assign match    = rd_v && rd_data.valid && (rd_data.blk == in_blk) &&
                    (rd_data.ofs == in_ofs);
  assign scan_end = (scan_addr == CW'(ENTRIES));
  assign slot_ok  = (32'(in_slot) < ENTRIES);
  assign slot_idx = AW'(in_slot);
  assign empty    = (free_count == '0);
  assign is_root  = (rd_data.refs == COUNT_ONE) && (rd_data.pblk == rd_data.blk) &&
                    (rd_data.pofs == rd_data.ofs);

  assign status.clear_done  = (clr_addr == AW'(ENTRIES - 1));
  assign status.hit         = match;
  assign status.scan_miss   = rd_v && (rd_addr == AW'(ENTRIES - 1)) && !match;
  assign status.stack_empty = empty;
  assign status.slot_ok     = slot_ok;

  always_comb begin
    ent_we             = 1'b0;
    ent_waddr          = rd_addr;
    ent_wdata          = rd_data;
    ent_re             = 1'b0;
    ent_raddr          = AW'(scan_addr);
    stk_we             = 1'b0;
    stk_waddr          = AW'(free_count);
    stk_wdata          = rd_addr;
    stk_re             = 1'b0;
    stk_raddr          = AW'(free_count - 1'b1);
    free_count_next    = free_count;
    res_status_next    = RES_BAD_SLOT;
    res_slot_next      = in_slot;
    res_count_next     = '0;
    res_wb_next        = 1'b0;
    res_wb_block_next  = '0;
    res_wb_offset_next = '0;
    unique case (cmd.op)
      OP_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_addr;
        ent_wdata = '0;
        stk_we    = 1'b1;
        stk_waddr = clr_addr;
        stk_wdata = AW'(ENTRIES - 1) - clr_addr;
      end
      OP_IDLE: begin
      end
      OP_SCAN: begin
        ent_re = !match && !scan_end;
      end
      OP_HIT: begin
        res_slot_next = SLOT_W'(rd_addr);
        if (rd_data.refs == COUNT_MAX) begin
          res_status_next = RES_OVERFLOW;
          res_count_next  = rd_data.refs;
        end else begin
          res_status_next = RES_HIT;
          res_count_next  = rd_data.refs + 1'b1;
          ent_we          = cmd.commit;
          ent_wdata.refs  = rd_data.refs + 1'b1;
        end
      end
      OP_MISS: begin
        stk_re          = !empty;
        res_status_next = RES_FULL;
        res_slot_next   = '0;
      end
      OP_LOAD: begin
        ent_we          = cmd.commit;
        ent_waddr       = stk_q;
        ent_wdata       = '{valid: 1'b1, blk: in_blk, ofs: in_ofs, pblk: in_pblk,
                            pofs: in_pofs, refs: COUNT_ONE};
        if (cmd.commit) begin
          free_count_next = free_count - 1'b1;
        end
        res_status_next = RES_LOADED;
        res_slot_next   = SLOT_W'(stk_q);
        res_count_next  = COUNT_ONE;
      end
      OP_CHECK: begin
        ent_re    = slot_ok;
        ent_raddr = slot_idx;
      end
      OP_EVAL: begin
        priority if (!rd_data.valid || (rd_data.refs == '0)) begin
          res_status_next = RES_BAD_SLOT;
        end else if (is_root) begin
          res_status_next = RES_ROOT;
          res_count_next  = COUNT_ONE;
        end else if (rd_data.refs != COUNT_ONE) begin
          res_status_next = RES_RELEASED;
          res_count_next  = rd_data.refs - 1'b1;
          ent_we          = cmd.commit;
          ent_wdata.refs  = rd_data.refs - 1'b1;
        end else begin
          // Last reference gone: clear the slot and hand it back to the stack.
          res_status_next    = RES_FREED;
          res_wb_next        = in_mod;
          res_wb_block_next  = in_mod ? rd_data.blk : '0;
          res_wb_offset_next = in_mod ? rd_data.ofs : '0;
          ent_we             = cmd.commit;
          ent_wdata          = '0;
          if (cmd.commit && (free_count < CW'(ENTRIES))) begin
            stk_we          = 1'b1;
            free_count_next = free_count + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      free_count <= CW'(ENTRIES);
      rd_v       <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      free_count <= free_count_next;
      rd_v       <= ent_re && (cmd.op == OP_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_blk    <= key_block;
      in_ofs    <= key_offset;
      in_pblk   <= parent_block;
      in_pofs   <= parent_offset;
      in_slot   <= slot;
      in_mod    <= modified;
      scan_addr <= '0;
    end else if (ent_re && (cmd.op == OP_SCAN)) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (cmd.commit) begin
      res_status    <= res_status_next;
      res_slot      <= res_slot_next;
      res_count     <= OUT_COUNT_W'(res_count_next);
      res_wb        <= res_wb_next;
      res_wb_block  <= res_wb_block_next;
      res_wb_offset <= res_wb_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      rd_data <= entry_mem[ent_raddr];
      rd_addr <= ent_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stack_mem[stk_raddr];
    end
  end

endmodule

// ===== rtl/rce_ctrl.sv =====
// ============================================================================
// rce_ctrl: sequencing controller of the reference-counted entry cache
// Steps each request through scan, update and free-stack handling, and owns
// the request and result handshakes.
// ============================================================================
module rce_ctrl import rce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       func,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid;
  logic        fire;

  // The result register may be loaded once it is empty or being emptied.
  assign fire     = !out_valid || m_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (func == FUNC_PUT) ? S_CHECK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.hit) begin
          state_next = S_HIT;
        end else if (status.scan_miss) begin
          state_next = S_MISS;
        end
      end
      S_HIT, S_LOAD, S_EVAL: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      S_MISS: begin
        if (!status.stack_empty) begin
          state_next = S_LOAD;
        end else if (fire) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (status.slot_ok) begin
          state_next = S_EVAL;
        end else if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.op     = OP_IDLE;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_CLEAR: cmd.op = OP_CLEAR;
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_SCAN: cmd.op = OP_SCAN;
      S_HIT: begin
        cmd.op     = OP_HIT;
        cmd.commit = fire;
      end
      S_MISS: begin
        cmd.op     = OP_MISS;
        cmd.commit = fire && status.stack_empty;
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        cmd.commit = fire;
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        cmd.commit = fire && !status.slot_ok;
      end
      S_EVAL: begin
        cmd.op     = OP_EVAL;
        cmd.commit = fire;
      end
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/refcounted_entry_cache.sv =====
// ============================================================================
// refcounted_entry_cache: fully associative reference-counted entry cache
// Top level joining the sequencing controller and the table datapath.
// ============================================================================
// The cache holds ENTRIES slots, each keyed by directory block and entry
// offset, with a parent key and a COUNT_BITS reference count. A get request
// scans the entry memory one slot per cycle from slot 0 and stops at the
// first match. A miss that finds no match in any slot loads the request into
// a slot taken from the free stack, or reports a full table when the stack is
// empty; the entry memory has a single read port. A put request first reads
// the slot and then updates it. After reset the block clears the table and
// fills the free stack, and takes no request during that pass. One request
// is worked on at a time; the next may be taken while the previous result
// still waits in the output register.
module refcounted_entry_cache import rce_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: key_block[30:0], key_offset[36:31],
  // parent_block[67:37], parent_offset[73:68], slot[79:74], modified[80],
  // zero fill [87:81].
  input  logic [87:0] s_tdata,
  // s_tuser: func (0 get by key, 1 put by slot).
  input  logic        s_tuser,
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: slot_out[5:0], ref_count_out[21:6], writeback[22],
  // wb_block[53:23], wb_offset[59:54], zero fill [63:60].
  output logic [63:0] m_tdata,
  // m_tuser: status[2:0].
  output logic [2:0]  m_tuser
);

  dp_cmd_t     dp_cmd;
  dp_status_t  dp_status;

  res_status_t            res_status;
  logic [SLOT_W-1:0]      res_slot;
  logic [OUT_COUNT_W-1:0] res_count;
  logic                   res_wb;
  logic [BLK_W-1:0]       res_wb_block;
  logic [OFS_W-1:0]       res_wb_offset;

  rce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (dp_cmd),
    .status   (dp_status)
  );

  rce_datapath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .key_block     (s_tdata[30:0]),
    .key_offset    (s_tdata[36:31]),
    .parent_block  (s_tdata[67:37]),
    .parent_offset (s_tdata[73:68]),
    .slot          (s_tdata[79:74]),
    .modified      (s_tdata[80]),
    .res_status    (res_status),
    .res_slot      (res_slot),
    .res_count     (res_count),
    .res_wb        (res_wb),
    .res_wb_block  (res_wb_block),
    .res_wb_offset (res_wb_offset)
  );

  assign m_tdata = {4'b0000, res_wb_offset, res_wb_block, res_wb, res_count, res_slot};
  assign m_tuser = res_status;

`ifndef NO_ASSERTIONS
  // Work on a request only starts after the handshake, so the controller
  // never offers to take a second request in the very next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while the previous one was still in progress");

  // A result is only written into the output register when it is free.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

  // A writeback is only ever requested by the freeing of an entry.
  a_wb_only_freed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[22]) |-> (m_tuser == RES_FREED))
    else $error("writeback flagged on a result that freed no entry");

  // A freshly loaded entry always starts with a single reference.
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == RES_LOADED)) |-> (m_tdata[21:6] == 16'd1))
    else $error("loaded entry reported with a count other than one");
`endif

endmodule
